// ----- rtl/core/brt_pkg.sv -----
// Shared types, operation codes and defaults for the binary radix sorter.
package brt_pkg;

	localparam int KEY_WIDTH_DEF = 32;
	localparam int MAX_KEYS_DEF  = 64;
	localparam int FIELD_W       = 32;

	// Cell operations driven by the sequencer
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_SORT  = 2'd2;
	localparam logic [1:0] OP_DRAIN = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] key_value;
		logic               last_key;
	} brt_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] sorted_value;
		logic               end_of_set;
		logic               overflowed;
	} brt_out_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic [1:0] op;
		logic       phase;
		logic       flip;
	} brt_ctl_t;

endpackage

// ----- rtl/core/binary_radix_sorter_core.sv -----
// Key sorter top level: loads keys into a chain of cells, sorts by odd-even exchange, drains in order.
// Load: one key per cycle while collecting a set.
// After the closing key: odd-even exchange phases in the cell chain, then one result per cycle
// while out_stall is low, the smallest first; input stalls from the closing key until the last
// result transfers.
// Reset clears the control state, key count, overflow flag and signed_mode; cell keys are not reset.
module binary_radix_sorter_core
	import brt_pkg::*;
#(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int MAX_KEYS  = MAX_KEYS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  brt_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output brt_out_t out_data,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int PW = $clog2(MAX_KEYS);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic [PW-1:0]        phase_q;
	logic                 flip_q;
	logic                 signed_mode_q;

	logic                 in_xfer;
	logic                 out_xfer;
	logic                 has_room;
	brt_ctl_t             ctl;
	logic [KEY_WIDTH+FIELD_W-1:0] key_ext;
	logic [KEY_WIDTH+FIELD_W-1:0] out_ext;
	logic [KEY_WIDTH-1:0] key_in;
	logic [KEY_WIDTH-1:0] cell_key [MAX_KEYS];

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid && !out_stall;
	assign has_room  = (count_q < CW'(MAX_KEYS));

	// keep the low KEY_WIDTH bits of the incoming key
	assign key_ext = {{KEY_WIDTH{1'b0}}, in_data.key_value};
	assign key_in  = key_ext[KEY_WIDTH-1:0];

	// cell operation for this cycle
	always_comb begin
		ctl.phase = phase_q[0];
		ctl.flip  = flip_q;
		ctl.op    = OP_HOLD;
		case (state_q)
			ST_LOAD: if (in_xfer && has_room) ctl.op = OP_LOAD;
			ST_SORT: ctl.op = OP_SORT;
			ST_EMIT: if (out_xfer) ctl.op = OP_DRAIN;
			default: ctl.op = OP_HOLD;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	// sequencer: load, sort phases, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			phase_q <= '0;
			flip_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (has_room) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
						if (in_data.last_key) begin
							state_q <= ST_SORT;
							phase_q <= '0;
							flip_q  <= signed_mode_q;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == PW'(MAX_KEYS - 1)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_xfer) begin
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// chain of cells; entries below count_q hold the set
	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_k;
		logic [KEY_WIDTH-1:0] right_k;
		logic                 lo_en;
		logic                 up_en;

		if (i == 0) begin : g_first
			assign left_k = key_in;
			assign up_en  = 1'b0;
		end else begin : g_mid
			assign left_k = cell_key[i-1];
			assign up_en  = (CW'(i) < count_q);
		end

		if (i == MAX_KEYS - 1) begin : g_last
			assign right_k = '0;
			assign lo_en   = 1'b0;
		end else begin : g_inner
			assign right_k = cell_key[i+1];
			assign lo_en   = (CW'(i + 1) < count_q);
		end

		brt_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.ODD_POS   (1'(i % 2))
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.lo_en     (lo_en),
			.up_en     (up_en),
			.left_key  (left_k),
			.right_key (right_k),
			.key       (cell_key[i])
		);
	end

	// result: head of the chain
	assign out_ext               = {{FIELD_W{1'b0}}, cell_key[0]};
	assign out_data.sorted_value = out_ext[FIELD_W-1:0];
	assign out_data.end_of_set   = (count_q == CW'(1));
	assign out_data.overflowed   = ovf_q;

endmodule

// ----- rtl/core/brt_cell.sv -----
// One cell of the sorting chain: holds a key, shifts or compare-exchanges with a neighbor.
module brt_cell
	import brt_pkg::*;
#(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter bit ODD_POS   = 1'b0
) (
	input  logic                 clk,
	input  brt_ctl_t             ctl,
	input  logic                 lo_en,
	input  logic                 up_en,
	input  logic [KEY_WIDTH-1:0] left_key,
	input  logic [KEY_WIDTH-1:0] right_key,
	output logic [KEY_WIDTH-1:0] key
);

	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] top_mask;
	logic                 is_lower;
	logic                 swap_right;
	logic                 swap_left;

	// signed order: invert the top bit before comparing
	assign top_mask   = {ctl.flip, {(KEY_WIDTH-1){1'b0}}};
	assign is_lower   = (ODD_POS == ctl.phase);
	assign swap_right = (key_q ^ top_mask) > (right_key ^ top_mask);
	assign swap_left  = (left_key ^ top_mask) > (key_q ^ top_mask);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: key_q <= left_key;
			OP_DRAIN: key_q <= right_key;
			OP_SORT: begin
				if (is_lower) begin
					if (lo_en && swap_right) key_q <= right_key;
				end else begin
					if (up_en && swap_left) key_q <= left_key;
				end
			end
			default: key_q <= key_q;
		endcase
	end

	assign key = key_q;

endmodule
